### sv/phss_pkg.sv
// Package for the peak-hold seven-segment scanner: types, codes and the segment table.
package phss_pkg;

  localparam int unsigned SampleWidth  = 10;
  localparam int unsigned EnableWidth  = 5;
  localparam int unsigned SegmentWidth = 7;
  localparam int unsigned DigitWidth   = 4;

  // Input item kinds
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // Table code shown in the unit-letter phase
  localparam logic [DigitWidth-1:0] UNIT_LETTER_CODE = 4'd10;

  // Digit-enable masks
  localparam logic [EnableWidth-1:0] EN_BLANK    = 5'd0;
  localparam logic [EnableWidth-1:0] EN_HUNDREDS = 5'd1;
  localparam logic [EnableWidth-1:0] EN_TENS     = 5'd2;
  localparam logic [EnableWidth-1:0] EN_UNITS    = 5'd4;
  localparam logic [EnableWidth-1:0] EN_LETTER   = 5'd16;

  // Scan phases; codes six and seven cannot arise from reset
  typedef enum logic [2:0] {
    PH_BLANK_LEAD  = 3'd0,
    PH_HUNDREDS    = 3'd1,
    PH_TENS        = 3'd2,
    PH_UNITS       = 3'd3,
    PH_BLANK_TRAIL = 3'd4,
    PH_LETTER      = 3'd5
  } phss_phase_t;

  // Decimal digits of the held peak
  typedef struct packed {
    logic [DigitWidth-1:0] hundreds;
    logic [DigitWidth-1:0] tens;
    logic [DigitWidth-1:0] units;
  } phss_digits_t;

  // Segment table, kept with its duplicate patterns
  function automatic logic [SegmentWidth-1:0] seg_pattern(input logic [DigitWidth-1:0] code);
    logic [SegmentWidth-1:0] pat;
    unique case (code)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h09;
      4'd2:    pat = 7'h5E;
      4'd3:    pat = 7'h5B;
      4'd4:    pat = 7'h69;
      4'd5:    pat = 7'h73;
      4'd6:    pat = 7'h77;
      4'd7:    pat = 7'h19;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h7B;
      4'd10:   pat = 7'h7D;
      4'd11:   pat = 7'h7F;
      4'd12:   pat = 7'h36;
      4'd13:   pat = 7'h3F;
      4'd14:   pat = 7'h76;
      default: pat = 7'h74;
    endcase
    return pat;
  endfunction

endpackage

### sv/phss_if.sv
// Stream interfaces for the scanner's input items and result items.
interface phss_in_if
  import phss_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [SampleWidth-1:0] sample_value;

  modport source (output valid, output func, output sample_value, input ready);
  modport sink   (input valid, input func, input sample_value, output ready);
endinterface

interface phss_out_if
  import phss_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [EnableWidth-1:0]  digit_enable;
  logic [SegmentWidth-1:0] segment_pattern;
  logic [SampleWidth-1:0]  held_peak;

  modport source (output valid, output digit_enable, output segment_pattern,
                  output held_peak, input ready);
  modport sink   (input valid, input digit_enable, input segment_pattern,
                  input held_peak, output ready);
endinterface

### sv/phss_digit_split.sv
// Splits the held peak into hundreds, tens and units by reciprocal multiplication.
module phss_digit_split
  import phss_pkg::*;
  (
  input  logic [SampleWidth-1:0] value,
  output phss_digits_t           digits
);

  // value * 41 >> 12 equals value / 100 for every 10-bit value
  logic [15:0] hund_prod;
  logic [3:0]  hund;
  logic [10:0] hund_back;
  logic [6:0]  rem100;
  // rem * 205 >> 11 equals rem / 10 for rem below 100
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_back;

  always_comb begin
    hund_prod = 16'(value) * 16'd41;
    hund      = hund_prod[15:12];
    hund_back = 11'(hund) * 11'd100;
    rem100    = 7'(11'(value) - hund_back);
    tens_prod = 15'(rem100) * 15'd205;
    tens      = tens_prod[14:11];
    tens_back = 7'(tens) * 7'd10;
    digits.hundreds = hund;
    digits.tens     = tens;
    digits.units    = 4'(rem100 - tens_back);
  end

endmodule

### sv/peak_hold_seven_segment_scanner.sv
// Top level of the peak-hold meter with a multiplexed seven-segment scanner.
//
// Use: items arrive on the samples channel. A beat with func low offers a
// converter reading; the block keeps the largest reading since reset and
// returns nothing. A beat with func high is a scan tick: it steps the
// six-phase scan counter and returns one beat on the results channel with
// the digit-enable mask, the segment pattern and the held peak.
// Phases one to three drive hundreds, tens and units, phase five the unit
// letter, and phases zero and four blank the digits while the segment latch
// keeps its last pattern.
// Latency: a tick's result is valid in the cycle after its beat is taken.
// Throughput: one item per cycle unless stalled; the digit split and table
// lookup sit between the input handshake and the single result register.
// Reset (rst, synchronous): peak, phase and segment latch clear to zero and
// the result register empties.
// Stall: a waiting result holds; samples.ready stays high while the result
// register is empty or being taken in the same cycle, so an item can be taken
// alongside each result that leaves.
module peak_hold_seven_segment_scanner
  import phss_pkg::*;
  (
  input  logic            clk,
  input  logic            rst,
  phss_in_if.sink         samples,
  phss_out_if.source      results
);

  logic [SampleWidth-1:0]  peak_value;
  logic [SampleWidth-1:0]  peak_value_next;
  phss_phase_t             scan_phase;
  phss_phase_t             scan_phase_next;
  logic [SegmentWidth-1:0] segment_latch;
  logic [SegmentWidth-1:0] segment_latch_next;
  logic [EnableWidth-1:0]  enable_next;
  logic                    out_valid;
  logic [EnableWidth-1:0]  out_enable;
  logic [SegmentWidth-1:0] out_segment;
  logic [SampleWidth-1:0]  out_peak;
  logic                    take;
  logic                    tick;
  phss_digits_t            digits;

  assign samples.ready = !out_valid || results.ready;
  assign take          = samples.valid && samples.ready;
  assign tick          = take && (samples.func == FUNC_TICK);

  phss_digit_split u_split (
    .value  (peak_value),
    .digits (digits)
  );

  // Keep the largest reading
  always_comb begin
    peak_value_next = peak_value;
    if (take && samples.func == FUNC_SAMPLE && samples.sample_value > peak_value) begin
      peak_value_next = samples.sample_value;
    end
  end

  // Advance the scan phase, wrapping past the letter phase
  always_comb begin
    unique case (scan_phase)
      PH_BLANK_LEAD:  scan_phase_next = PH_HUNDREDS;
      PH_HUNDREDS:    scan_phase_next = PH_TENS;
      PH_TENS:        scan_phase_next = PH_UNITS;
      PH_UNITS:       scan_phase_next = PH_BLANK_TRAIL;
      PH_BLANK_TRAIL: scan_phase_next = PH_LETTER;
      default:        scan_phase_next = PH_BLANK_LEAD;
    endcase
  end

  // Drive enable and segment latch for the phase being entered
  always_comb begin
    enable_next        = EN_BLANK;
    segment_latch_next = segment_latch;
    unique case (scan_phase_next)
      PH_HUNDREDS: begin
        enable_next        = EN_HUNDREDS;
        segment_latch_next = seg_pattern(digits.hundreds);
      end
      PH_TENS: begin
        enable_next        = EN_TENS;
        segment_latch_next = seg_pattern(digits.tens);
      end
      PH_UNITS: begin
        enable_next        = EN_UNITS;
        segment_latch_next = seg_pattern(digits.units);
      end
      PH_LETTER: begin
        enable_next        = EN_LETTER;
        segment_latch_next = seg_pattern(UNIT_LETTER_CODE);
      end
      default: begin
        enable_next        = EN_BLANK;
        segment_latch_next = segment_latch;
      end
    endcase
  end

  // Update state
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_value    <= '0;
      scan_phase    <= PH_BLANK_LEAD;
      segment_latch <= '0;
    end else begin
      peak_value <= peak_value_next;
      if (tick) begin
        scan_phase    <= scan_phase_next;
        segment_latch <= segment_latch_next;
      end
    end
  end

  // Hold the result beat until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (samples.ready) begin
      out_valid <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_enable  <= enable_next;
      out_segment <= segment_latch_next;
      out_peak    <= peak_value;
    end
  end

  assign results.valid           = out_valid;
  assign results.digit_enable    = out_enable;
  assign results.segment_pattern = out_segment;
  assign results.held_peak       = out_peak;

  // A taken tick always leaves a result beat behind
  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    tick |=> results.valid)
    else $error("tick beat produced no result");

  // A sample never lowers the held peak
  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> peak_value >= $past(peak_value))
    else $error("held peak decreased");

  // A larger reading becomes the peak
  a_peak_capture: assert property (@(posedge clk) disable iff (rst)
    (take && samples.func == FUNC_SAMPLE && samples.sample_value > peak_value)
    |=> peak_value == $past(samples.sample_value))
    else $error("larger reading not captured");

  // At most one digit is driven at a time
  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> $onehot0(results.digit_enable))
    else $error("more than one digit enabled");

  // The phase never leaves the six-phase cycle
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    tick |=> (3'(scan_phase) <= 3'(PH_LETTER)))
    else $error("scan phase out of range");

endmodule

### dv/tb.sv
// Testbench for the peak-hold seven-segment scanner: random handshakes and a result check.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import phss_pkg::*;

  localparam int unsigned QuietLimit = 2000;

  // Segment drive per table code, code 15 first; the duplicate patterns are intended
  localparam logic [15:0][SegmentWidth-1:0] SEGMENTS = {
    7'h74, 7'h76, 7'h3F, 7'h36, 7'h7F, 7'h7D, 7'h7B, 7'h7F,
    7'h19, 7'h77, 7'h73, 7'h69, 7'h5B, 7'h5E, 7'h09, 7'h3F
  };

  typedef struct packed {
    logic [EnableWidth-1:0]  digit_enable;
    logic [SegmentWidth-1:0] segment_pattern;
    logic [SampleWidth-1:0]  held_peak;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  phss_in_if  in_if ();
  phss_out_if out_if ();

  peak_hold_seven_segment_scanner u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (in_if),
    .results (out_if)
  );

  // Local copy of the display state
  logic [SampleWidth-1:0]  peak_seen  = '0;
  phss_phase_t             phase_now  = PH_BLANK_LEAD;
  logic [SegmentWidth-1:0] latch_now  = '0;
  scan_result_t            predicted_scans[$];

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  bit          src_burst    = 1'b0;
  bit          sink_burst   = 1'b0;

  initial forever #6 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("tb: mismatch at %0t: %s", $realtime, what);
  endtask

  // Step the scan counter and queue the display beat that the tick should produce
  task automatic predict_tick();
    int           hundreds;
    int           tens;
    int           units;
    scan_result_t res;
    hundreds = peak_seen / 100;
    tens     = (peak_seen % 100) / 10;
    units    = peak_seen % 10;
    phase_now = (phase_now >= PH_LETTER) ? PH_BLANK_LEAD : phss_phase_t'(phase_now + 3'd1);
    res.digit_enable = EN_BLANK;
    case (phase_now)
      PH_HUNDREDS: begin
        res.digit_enable = EN_HUNDREDS;
        latch_now = SEGMENTS[hundreds];
      end
      PH_TENS: begin
        res.digit_enable = EN_TENS;
        latch_now = SEGMENTS[tens];
      end
      PH_UNITS: begin
        res.digit_enable = EN_UNITS;
        latch_now = SEGMENTS[units];
      end
      PH_LETTER: begin
        res.digit_enable = EN_LETTER;
        latch_now = SEGMENTS[UNIT_LETTER_CODE];
      end
      default: ;
    endcase
    res.segment_pattern = latch_now;
    res.held_peak       = peak_seen;
    predicted_scans.push_back(res);
  endtask

  // Offer one beat after a random gap and hold it until taken
  task automatic send_item(input logic f, input logic [SampleWidth-1:0] v);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= f;
    in_if.sample_value <= v;
    do @(posedge clk); while (!in_if.ready);
    if (f == FUNC_TICK) begin
      predict_tick();
    end else if (v > peak_seen) begin
      peak_seen = v;
    end
  endtask

  task automatic send_tick();
    send_item(FUNC_TICK, SampleWidth'($urandom_range(0, 1023)));
  endtask

  // Hold off the sender until every display beat has come back
  task automatic wait_results_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (predicted_scans.size() != 0) @(posedge clk);
  endtask

  // Full scan at a zero peak, blank phases repeating the latch
  task automatic test_reset_display();
    repeat (6) send_tick();
    send_item(FUNC_SAMPLE, 10'd0);
  endtask

  // Single and two-digit peaks, with a smaller reading that must not lower the peak
  task automatic test_digit_split();
    send_item(FUNC_SAMPLE, 10'd7);
    send_item(FUNC_SAMPLE, 10'd3);
    repeat (3) send_tick();
    send_item(FUNC_SAMPLE, 10'd58);
    repeat (2) send_tick();
  endtask

  // Climb the peak slowly so that every digit value gets shown, with noise below the peak
  task automatic test_random_climb();
    int unsigned cand;
    int          pick;
    for (int i = 0; i < 1400; i++) begin
      if (i % 64 == 0) begin
        src_burst  = ($urandom_range(0, 3) == 0);
        sink_burst = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 1) == 1) begin
        send_tick();
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          cand = peak_seen + $urandom_range(0, 5);
          if (cand > 999) cand = 999;
        end else begin
          cand = $urandom_range(0, peak_seen);
        end
        send_item(FUNC_SAMPLE, SampleWidth'(cand));
      end
    end
    src_burst  = 1'b0;
    sink_burst = 1'b0;
  endtask

  // Peaks of a thousand and above give a hundreds code of ten; top of range last
  task automatic test_hundreds_of_ten();
    send_item(FUNC_SAMPLE, 10'd1000);
    repeat (6) send_tick();
    send_item(FUNC_SAMPLE, 10'd1023);
    send_item(FUNC_SAMPLE, 10'd512);
    repeat (6) send_tick();
  endtask

  // Result sink: stall for a random number of cycles before each beat
  initial begin
    int gap;
    out_if.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      gap = sink_burst ? 0 : $urandom_range(0, 14);
      @(negedge clk);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    scan_result_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (predicted_scans.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = predicted_scans.pop_front();
        if (out_if.digit_enable !== want.digit_enable)
          report_mismatch($sformatf("digit_enable got %0d want %0d",
                                    out_if.digit_enable, want.digit_enable));
        if (out_if.segment_pattern !== want.segment_pattern)
          report_mismatch($sformatf("segment_pattern got 'h%0h want 'h%0h",
                                    out_if.segment_pattern, want.segment_pattern));
        if (out_if.held_peak !== want.held_peak)
          report_mismatch($sformatf("held_peak got %0d want %0d",
                                    out_if.held_peak, want.held_peak));
      end
    end
  end

  // Stop a hung run: count cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid        = 1'b0;
    in_if.func         = FUNC_SAMPLE;
    in_if.sample_value = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_reset_display();
    test_digit_split();
    test_random_climb();
    wait_results_drained();
    test_hundreds_of_ten();
    wait_results_drained();

    // Allow for the result register, then catch any stray beat
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
